[design/lcaq_pkg.sv]
// Shared types and constants of the lowest-common-ancestor query core.
// Depends on nothing; lcaq_ctrl and the top level refer to it by scoped names.
`default_nettype none

package lcaq_pkg;

   // default node capacity
   localparam int MAX_NODES_DEF = 1024;

   // fixed field widths of the request, response and register
   localparam int CMD_W   = 2;
   localparam int POS_W   = 11;
   localparam int NODE_W  = 10;
   localparam int LEVEL_W = 11;
   localparam int COUNT_W = 11;

   // node count after reset
   localparam int NODE_COUNT_RST = 1024;

   // request commands
   localparam logic [CMD_W-1:0] CMD_TOUR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_VISIT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BUILD = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

   // response kinds
   localparam logic KIND_BUILD = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // one response
   typedef struct packed {
      logic              kind;
      logic [NODE_W-1:0] lca_node;
      logic              b_is_ancestor;
   } result_type;

endpackage

`default_nettype wire

[design/lcaq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module lcaq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[design/lcaq_ctrl.sv]
// Sequencer of the query core: tour, first-visit and sparse-table stores,
// table build loop and range-minimum query. Uses lcaq_pkg and lcaq_ram.
`default_nettype none

module lcaq_ctrl #(
   parameter int MAX_NODES = lcaq_pkg::MAX_NODES_DEF,
   localparam int TOUR_LEN = 2 * MAX_NODES,
   localparam int SPAN_W = $clog2(TOUR_LEN + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lcaq_pkg::CMD_W-1:0]           req_cmd,
   input  logic [lcaq_pkg::POS_W-1:0]           req_position,
   input  logic [lcaq_pkg::NODE_W-1:0]          req_node_a,
   input  logic signed [lcaq_pkg::LEVEL_W-1:0]  req_level,
   input  logic [lcaq_pkg::NODE_W-1:0]          req_node_b,
   input  logic [SPAN_W-1:0]                    span,
   input  logic                                 out_free,
   output logic                                 res_valid,
   output lcaq_pkg::result_type                 res
);

   localparam int PW = $clog2(TOUR_LEN);
   localparam int TABLE_COLS = SPAN_W;
   localparam int CB = $clog2(TABLE_COLS);
   localparam int NW = $clog2(MAX_NODES);
   localparam int TBL_DEPTH = TABLE_COLS * (2 ** PW);
   localparam int POS_X = (SPAN_W > lcaq_pkg::POS_W) ? SPAN_W : lcaq_pkg::POS_W;
   localparam int NODE_X = ($clog2(MAX_NODES + 1) > lcaq_pkg::NODE_W) ?
                           $clog2(MAX_NODES + 1) : lcaq_pkg::NODE_W;

   typedef enum logic [16:0] {
      ST_IDLE  = 17'h00001,
      ST_COL0  = 17'h00002,
      ST_B_RDP = 17'h00004,
      ST_B_RDQ = 17'h00008,
      ST_B_LVP = 17'h00010,
      ST_B_LVQ = 17'h00020,
      ST_B_WR  = 17'h00040,
      ST_Q_FVB = 17'h00080,
      ST_Q_SRT = 17'h00100,
      ST_Q_LEN = 17'h00200,
      ST_Q_TBP = 17'h00400,
      ST_Q_TBQ = 17'h00800,
      ST_Q_LVP = 17'h01000,
      ST_Q_LVQ = 17'h02000,
      ST_Q_NOD = 17'h04000,
      ST_Q_ANS = 17'h08000,
      ST_EMIT  = 17'h10000
   } state_type;

   state_type                        state_ff, state_in;
   logic [CB-1:0]                    col_ff, col_in;
   logic [PW-1:0]                    row_ff, row_in;
   logic [PW-1:0]                    p_ff, p_in;
   logic [PW-1:0]                    q_ff, q_in;
   logic [lcaq_pkg::LEVEL_W-1:0]     lp_ff, lp_in;
   logic [lcaq_pkg::NODE_W-1:0]      b_ff, b_in;
   logic                             a_ok_ff, a_ok_in;
   logic                             b_ok_ff, b_ok_in;
   logic [PW-1:0]                    va_ff, va_in;
   logic [PW-1:0]                    lo_ff, lo_in;
   logic [PW-1:0]                    hi_ff, hi_in;
   logic [CB-1:0]                    k_ff, k_in;
   logic [PW-1:0]                    row2_ff, row2_in;
   lcaq_pkg::result_type             res_ff, res_in;

   logic                             accept;
   logic                             tour_ok;
   logic                             visit_ok;
   logic                             step;
   logic                             last_row;
   logic                             more_cols;
   logic [SPAN_W:0]                  w_cur;
   logic [SPAN_W:0]                  w_next;
   logic [SPAN_W:0]                  w_k;
   logic [SPAN_W-1:0]                half;
   logic [SPAN_W-1:0]                len;
   logic [CB-1:0]                    len_msb;
   logic [PW-1:0]                    vb;

   // memory ports
   logic                             tour_we;
   logic                             fv_we;
   logic                             fv_re;
   logic [NW-1:0]                    fv_raddr;
   logic [lcaq_pkg::POS_W-1:0]       fv_rdata;
   logic                             tbl_we;
   logic [PW-1:0]                    tbl_wdata;
   logic                             tbl_re;
   logic [CB-1:0]                    tbl_rcol;
   logic [PW-1:0]                    tbl_rrow;
   logic [PW-1:0]                    tbl_rdata;
   logic                             lvl_re;
   logic [PW-1:0]                    lvl_raddr;
   logic [lcaq_pkg::LEVEL_W-1:0]     lvl_rdata;
   logic                             node_re;
   logic [PW-1:0]                    node_raddr;
   logic [lcaq_pkg::NODE_W-1:0]      node_rdata;

   // first visit beyond the span is pulled back to its last position
   function automatic logic [PW-1:0] clip_visit(input logic [lcaq_pkg::POS_W-1:0] v,
                                                input logic [SPAN_W-1:0] n);
      logic [POS_X-1:0] v_x;
      logic [POS_X-1:0] n_x;
      v_x = POS_X'(v);
      n_x = POS_X'(n);
      clip_visit = (v_x >= n_x) ? PW'(n_x - POS_X'(1)) : PW'(v_x);
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign res       = res_ff;
   assign tour_ok   = POS_X'(req_position) < POS_X'(TOUR_LEN);
   assign visit_ok  = NODE_X'(req_node_a) < NODE_X'(MAX_NODES);

   // loop bounds of the build and window arithmetic of the query
   always_comb begin
      w_cur     = (SPAN_W+1)'(1) << col_ff;
      w_next    = w_cur << 1;
      half      = SPAN_W'(1) << (col_ff - 1'b1);
      last_row  = ((SPAN_W+1)'(row_ff) + w_cur) == (SPAN_W+1)'(span);
      more_cols = (((CB+1)'(col_ff) + (CB+1)'(1)) < (CB+1)'(TABLE_COLS)) &&
                  (w_next <= (SPAN_W+1)'(span));
      len       = SPAN_W'(hi_ff - lo_ff) + SPAN_W'(1);
      w_k       = (SPAN_W+1)'(1) << k_ff;
      len_msb   = '0;
      for (int i = 0; i < SPAN_W; i++) begin
         if (len[i]) begin
            len_msb = CB'(i);
         end
      end
      vb = clip_visit(b_ok_ff ? fv_rdata : '0, span);
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      p_in       = p_ff;
      q_in       = q_ff;
      lp_in      = lp_ff;
      b_in       = b_ff;
      a_ok_in    = a_ok_ff;
      b_ok_in    = b_ok_ff;
      va_in      = va_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      k_in       = k_ff;
      row2_in    = row2_ff;
      res_in     = res_ff;
      step       = 1'b0;
      res_valid  = 1'b0;
      tour_we    = 1'b0;
      fv_we      = 1'b0;
      fv_re      = 1'b0;
      fv_raddr   = NW'(b_ff);
      tbl_we     = 1'b0;
      tbl_wdata  = row_ff;
      tbl_re     = 1'b0;
      tbl_rcol   = k_ff;
      tbl_rrow   = lo_ff;
      lvl_re     = 1'b0;
      lvl_raddr  = p_ff;
      node_re    = 1'b0;
      node_raddr = p_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  lcaq_pkg::CMD_TOUR: begin
                     tour_we = tour_ok;
                  end
                  lcaq_pkg::CMD_VISIT: begin
                     fv_we = visit_ok;
                  end
                  lcaq_pkg::CMD_BUILD: begin
                     row_in   = '0;
                     col_in   = '0;
                     state_in = ST_COL0;
                  end
                  lcaq_pkg::CMD_QUERY: begin
                     b_in    = req_node_b;
                     a_ok_in = NODE_X'(req_node_a) < NODE_X'(MAX_NODES);
                     b_ok_in = NODE_X'(req_node_b) < NODE_X'(MAX_NODES);
                     if (req_node_a == '0 || req_node_b == '0) begin
                        res_in.kind          = lcaq_pkg::KIND_QUERY;
                        res_in.lca_node      = '0;
                        res_in.b_is_ancestor = (req_node_b == '0);
                        state_in             = ST_EMIT;
                     end else if (req_node_a == req_node_b) begin
                        res_in.kind          = lcaq_pkg::KIND_QUERY;
                        res_in.lca_node      = req_node_a;
                        res_in.b_is_ancestor = 1'b1;
                        state_in             = ST_EMIT;
                     end else begin
                        fv_re    = 1'b1;
                        fv_raddr = NW'(req_node_a);
                        state_in = ST_Q_FVB;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         // column 0: every row is its own minimum
         ST_COL0: begin
            tbl_we    = 1'b1;
            tbl_wdata = row_ff;
            step      = 1'b1;
         end
         ST_B_RDP: begin
            tbl_re   = 1'b1;
            tbl_rcol = col_ff - 1'b1;
            tbl_rrow = row_ff;
            state_in = ST_B_RDQ;
         end
         ST_B_RDQ: begin
            tbl_re   = 1'b1;
            tbl_rcol = col_ff - 1'b1;
            tbl_rrow = PW'(SPAN_W'(row_ff) + half);
            p_in     = tbl_rdata;
            state_in = ST_B_LVP;
         end
         ST_B_LVP: begin
            q_in      = tbl_rdata;
            lvl_re    = 1'b1;
            lvl_raddr = p_ff;
            state_in  = ST_B_LVQ;
         end
         ST_B_LVQ: begin
            lp_in     = lvl_rdata;
            lvl_re    = 1'b1;
            lvl_raddr = q_ff;
            state_in  = ST_B_WR;
         end
         // ties go to the second half
         ST_B_WR: begin
            tbl_we    = 1'b1;
            tbl_wdata = ($signed(lp_ff) < $signed(lvl_rdata)) ? p_ff : q_ff;
            step      = 1'b1;
         end
         ST_Q_FVB: begin
            va_in    = clip_visit(a_ok_ff ? fv_rdata : '0, span);
            fv_re    = 1'b1;
            fv_raddr = NW'(b_ff);
            state_in = ST_Q_SRT;
         end
         ST_Q_SRT: begin
            lo_in    = (va_ff > vb) ? vb : va_ff;
            hi_in    = (va_ff > vb) ? va_ff : vb;
            state_in = ST_Q_LEN;
         end
         ST_Q_LEN: begin
            k_in     = len_msb;
            state_in = ST_Q_TBP;
         end
         ST_Q_TBP: begin
            tbl_re   = 1'b1;
            tbl_rcol = k_ff;
            tbl_rrow = lo_ff;
            row2_in  = PW'((SPAN_W+1)'(hi_ff) + (SPAN_W+1)'(1) - w_k);
            state_in = ST_Q_TBQ;
         end
         ST_Q_TBQ: begin
            tbl_re   = 1'b1;
            tbl_rcol = k_ff;
            tbl_rrow = row2_ff;
            p_in     = tbl_rdata;
            state_in = ST_Q_LVP;
         end
         ST_Q_LVP: begin
            q_in      = tbl_rdata;
            lvl_re    = 1'b1;
            lvl_raddr = p_ff;
            state_in  = ST_Q_LVQ;
         end
         ST_Q_LVQ: begin
            lp_in     = lvl_rdata;
            lvl_re    = 1'b1;
            lvl_raddr = q_ff;
            state_in  = ST_Q_NOD;
         end
         // ties go to the left window
         ST_Q_NOD: begin
            node_re    = 1'b1;
            node_raddr = ($signed(lp_ff) <= $signed(lvl_rdata)) ? p_ff : q_ff;
            state_in   = ST_Q_ANS;
         end
         ST_Q_ANS: begin
            res_in.kind          = lcaq_pkg::KIND_QUERY;
            res_in.lca_node      = node_rdata;
            res_in.b_is_ancestor = (node_rdata == b_ff);
            state_in             = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // advance the build to the next row or column, or end it with a build response
      if (step) begin
         if (!last_row) begin
            row_in   = row_ff + 1'b1;
            state_in = (state_ff == ST_COL0) ? ST_COL0 : ST_B_RDP;
         end else if (more_cols) begin
            row_in   = '0;
            col_in   = col_ff + 1'b1;
            state_in = ST_B_RDP;
         end else begin
            res_in.kind          = lcaq_pkg::KIND_BUILD;
            res_in.lca_node      = '0;
            res_in.b_is_ancestor = 1'b0;
            state_in             = ST_EMIT;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      row_ff  <= row_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      lp_ff   <= lp_in;
      b_ff    <= b_in;
      a_ok_ff <= a_ok_in;
      b_ok_ff <= b_ok_in;
      va_ff   <= va_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      k_ff    <= k_in;
      row2_ff <= row2_in;
      res_ff  <= res_in;
   end

   // tour node store
   lcaq_ram #(
      .WIDTH (lcaq_pkg::NODE_W),
      .DEPTH (TOUR_LEN)
   ) u_node_ram (
      .clock (clock),
      .we    (tour_we),
      .waddr (PW'(req_position)),
      .wdata (req_node_a),
      .re    (node_re),
      .raddr (node_raddr),
      .rdata (node_rdata)
   );

   // tour level store
   lcaq_ram #(
      .WIDTH (lcaq_pkg::LEVEL_W),
      .DEPTH (TOUR_LEN)
   ) u_level_ram (
      .clock (clock),
      .we    (tour_we),
      .waddr (PW'(req_position)),
      .wdata (req_level),
      .re    (lvl_re),
      .raddr (lvl_raddr),
      .rdata (lvl_rdata)
   );

   // first-visit store
   lcaq_ram #(
      .WIDTH (lcaq_pkg::POS_W),
      .DEPTH (MAX_NODES)
   ) u_visit_ram (
      .clock (clock),
      .we    (fv_we),
      .waddr (NW'(req_node_a)),
      .wdata (req_position),
      .re    (fv_re),
      .raddr (fv_raddr),
      .rdata (fv_rdata)
   );

   // sparse min-index table, addressed by column then row
   lcaq_ram #(
      .WIDTH (PW),
      .DEPTH (TBL_DEPTH)
   ) u_table_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr ({col_ff, row_ff}),
      .wdata (tbl_wdata),
      .re    (tbl_re),
      .raddr ({tbl_rcol, tbl_rrow}),
      .rdata (tbl_rdata)
   );

   // a build or query request keeps the sequencer busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == lcaq_pkg::CMD_BUILD || req_cmd == lcaq_pkg::CMD_QUERY))
      |=> !req_ready)
      else $error("sequencer ready right after a build or query request");

   // build writes only windows that lie inside the span
   a_build_window: assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> (((SPAN_W+1)'(row_ff) + w_cur) <= (SPAN_W+1)'(span)))
      else $error("table write beyond the span");

   // the two query windows start at lo and end at hi
   a_query_windows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_TBQ) |->
      (((SPAN_W+1)'(row2_ff) + w_k) == ((SPAN_W+1)'(hi_ff) + (SPAN_W+1)'(1))) &&
      (row2_ff >= lo_ff) &&
      (((SPAN_W+1)'(lo_ff) + w_k) <= ((SPAN_W+1)'(hi_ff) + (SPAN_W+1)'(1))))
      else $error("query windows do not cover the range");

   // sorted visits stay inside the span
   a_sorted_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_SRT) |=> (lo_ff <= hi_ff) && (SPAN_W'(hi_ff) < span))
      else $error("query range out of order or beyond the span");

   // after a response the sequencer is free again
   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> req_ready)
      else $error("sequencer not idle after a response");

endmodule

`default_nettype wire

[design/lca_sparse_table_query_core.sv]
// Top level of the lowest-common-ancestor query core: node-count register,
// span clamp, response register. Uses lcaq_pkg and lcaq_ctrl.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  req_cmd req_position req_node_a req_level req_node_b
//   rsp      out  rsp_valid/rsp_ready  rsp_kind rsp_lca_node rsp_b_is_ancestor
//   csr      in   csr_valid/csr_ready  csr_node_count
//
// Tour and first-visit writes leave the sequencer idle; a query with two distinct non-zero nodes
// runs a chain of dependent reads (first visits, table, levels, tour node)
// on RAMs with one read port each; a query with a zero or repeated node skips those reads.
// A build writes column 0 for N tour positions, N = 2*node_count, then builds the later columns
// one table entry at a time through the table RAM's single read port.
// Reset is synchronous; it clears the sequencer and response valid and sets the node count to 1024.
// A held response stalls the next build or query before its result, and all requests behind it.
`default_nettype none

module lca_sparse_table_query_core #(
   parameter int MAX_NODES = lcaq_pkg::MAX_NODES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lcaq_pkg::CMD_W-1:0]           req_cmd,
   input  logic [lcaq_pkg::POS_W-1:0]           req_position,
   input  logic [lcaq_pkg::NODE_W-1:0]          req_node_a,
   input  logic signed [lcaq_pkg::LEVEL_W-1:0]  req_level,
   input  logic [lcaq_pkg::NODE_W-1:0]          req_node_b,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_kind,
   output logic [lcaq_pkg::NODE_W-1:0]          rsp_lca_node,
   output logic                                 rsp_b_is_ancestor,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lcaq_pkg::COUNT_W-1:0]         csr_node_count
);

   localparam int TOUR_LEN = 2 * MAX_NODES;
   localparam int SPAN_W = $clog2(TOUR_LEN + 1);
   localparam int NE_W = ($clog2(MAX_NODES + 1) > lcaq_pkg::COUNT_W) ?
                         $clog2(MAX_NODES + 1) : lcaq_pkg::COUNT_W;
   localparam logic [SPAN_W-1:0] SPAN_RST = SPAN_W'(2 *
      ((lcaq_pkg::NODE_COUNT_RST > MAX_NODES) ? MAX_NODES : lcaq_pkg::NODE_COUNT_RST));

   logic [lcaq_pkg::COUNT_W-1:0] node_count_ff;
   logic [SPAN_W-1:0]            span_ff, span_in;
   logic [NE_W-1:0]              n_eff;
   logic                         rsp_valid_ff, rsp_valid_in;
   lcaq_pkg::result_type         rsp_res_ff;
   logic                         out_free;
   logic                         res_valid;
   lcaq_pkg::result_type         res;

   assign csr_ready = 1'b1;

   // node count clamped to 1..MAX_NODES, span is twice that
   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = NE_W'(1);
      end else if (NE_W'(node_count_ff) > NE_W'(MAX_NODES)) begin
         n_eff = NE_W'(MAX_NODES);
      end else begin
         n_eff = NE_W'(node_count_ff);
      end
      span_in = SPAN_W'({n_eff, 1'b0});
   end

   // register and span
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= lcaq_pkg::COUNT_W'(lcaq_pkg::NODE_COUNT_RST);
         span_ff       <= SPAN_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_node_count;
         end
         span_ff <= span_in;
      end
   end

   // response register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_res_ff.kind;
   assign rsp_lca_node      = rsp_res_ff.lca_node;
   assign rsp_b_is_ancestor = rsp_res_ff.b_is_ancestor;

   // sequencer with the stores
   lcaq_ctrl #(
      .MAX_NODES (MAX_NODES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .req_node_a   (req_node_a),
      .req_level    (req_level),
      .req_node_b   (req_node_b),
      .span         (span_ff),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res          (res)
   );

endmodule

`default_nettype wire
